// File: design/b64d_pkg.sv
// b64d_pkg: shared types, constants and decode functions of the base64 stream decoder.
// Depends on nothing; every design file imports it.
package b64d_pkg;

   // Alphabet boundaries and special characters
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;  // 'A'
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5a;  // 'Z'
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;  // 'a'
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7a;  // 'z'
   localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;  // '0'
   localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;  // '9'
   localparam logic [7:0] CHAR_PLUS    = 8'h2b;  // '+'
   localparam logic [7:0] CHAR_SLASH   = 8'h2f;  // '/'
   localparam logic [7:0] CHAR_PAD     = 8'h3d;  // '=', stops like any non-alphabet char

   localparam logic [5:0] SEXTET_LOWER_BASE = 6'd26;
   localparam logic [5:0] SEXTET_DIGIT_BASE = 6'd52;
   localparam logic [5:0] SEXTET_PLUS       = 6'd62;
   localparam logic [5:0] SEXTET_SLASH      = 6'd63;

   localparam logic [5:0] SEXTET_HI_MASK  = 6'h30;
   localparam logic [5:0] SEXTET_MID_MASK = 6'h3c;

   localparam logic [31:0] COUNT_MAX = 32'hffff_ffff;

   typedef struct packed {
      logic [7:0] in_char;
      logic       end_of_message;
   } req_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic        byte_valid;
      logic        message_done;
      logic [31:0] byte_count;
   } rsp_type;

   // Work item from the front end to the back end: up to three bytes, then
   // optionally the closing result of the message.
   typedef struct packed {
      logic [7:0] data0;
      logic [7:0] data1;
      logic [7:0] data2;
      logic [1:0] nbytes;
      logic       done;
   } cmd_type;

   typedef struct packed {
      logic       ok;
      logic [5:0] value;
   } sextet_type;

   typedef struct packed {
      logic [7:0] b0;
      logic [7:0] b1;
      logic [7:0] b2;
   } group_type;

   function automatic sextet_type sextet_of(logic [7:0] c);
      sextet_type s;
      s.ok    = 1'b1;
      s.value = 6'd0;
      if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
         s.value = 6'(c - CHAR_UPPER_A);
      end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
         s.value = 6'(c - CHAR_LOWER_A) + SEXTET_LOWER_BASE;
      end else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
         s.value = 6'(c - CHAR_DIGIT_0) + SEXTET_DIGIT_BASE;
      end else if (c == CHAR_PLUS) begin
         s.value = SEXTET_PLUS;
      end else if (c == CHAR_SLASH) begin
         s.value = SEXTET_SLASH;
      end else begin
         s.ok = 1'b0;
      end
      return s;
   endfunction

   function automatic group_type group_of(logic [5:0] s0, logic [5:0] s1,
                                          logic [5:0] s2, logic [5:0] s3);
      group_type g;
      g.b0 = {s0, 2'((s1 & SEXTET_HI_MASK) >> 4)};
      g.b1 = {s1[3:0], 4'((s2 & SEXTET_MID_MASK) >> 2)};
      g.b2 = {s2[1:0], s3};
      return g;
   endfunction

endpackage

// File: design/b64d_front.sv
// b64d_front: accepts characters, collects sextets and turns each transaction into a
// work item for the back end. Depends on b64d_pkg.
module b64d_front
   import b64d_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   input  logic    q_full,
   output logic    q_push,
   output cmd_type q_cmd
);

   logic [5:0] s0_ff, s1_ff, s2_ff;
   logic [5:0] s0_in, s1_in, s2_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       stopped_ff, stopped_in;
   logic       accept;
   sextet_type sx;
   group_type  grp;
   logic [1:0] nbytes;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      sx         = sextet_of(req_data.in_char);
      grp        = '0;
      nbytes     = 2'd0;
      s0_in      = s0_ff;
      s1_in      = s1_ff;
      s2_in      = s2_ff;
      cnt_in     = cnt_ff;
      stopped_in = stopped_ff;
      if (!stopped_ff) begin
         if (!sx.ok) begin
            // stop: partial group of k sextets gives k-1 bytes
            grp        = group_of(s0_ff, s1_ff, s2_ff, 6'd0);
            nbytes     = (cnt_ff > 2'd1) ? 2'(cnt_ff - 2'd1) : 2'd0;
            s0_in      = 6'd0;
            s1_in      = 6'd0;
            s2_in      = 6'd0;
            cnt_in     = 2'd0;
            stopped_in = 1'b1;
         end else if (cnt_ff == 2'd3) begin
            grp    = group_of(s0_ff, s1_ff, s2_ff, sx.value);
            nbytes = 2'd3;
            s0_in  = 6'd0;
            s1_in  = 6'd0;
            s2_in  = 6'd0;
            cnt_in = 2'd0;
         end else begin
            case (cnt_ff)
               2'd0:    s0_in = sx.value;
               2'd1:    s1_in = sx.value;
               default: s2_in = sx.value;
            endcase
            cnt_in = 2'(cnt_ff + 2'd1);
            if (req_data.end_of_message) begin
               // flush at end of message: k+1 sextets give k bytes
               grp    = group_of(s0_in, s1_in, s2_in, 6'd0);
               nbytes = cnt_ff;
            end
         end
      end
      if (req_data.end_of_message) begin
         s0_in      = 6'd0;
         s1_in      = 6'd0;
         s2_in      = 6'd0;
         cnt_in     = 2'd0;
         stopped_in = 1'b0;
      end
   end

   always_comb begin
      q_cmd.data0  = grp.b0;
      q_cmd.data1  = grp.b1;
      q_cmd.data2  = grp.b2;
      q_cmd.nbytes = nbytes;
      q_cmd.done   = req_data.end_of_message;
      q_push       = accept && (nbytes != 2'd0 || req_data.end_of_message);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_ff      <= 6'd0;
         s1_ff      <= 6'd0;
         s2_ff      <= 6'd0;
         cnt_ff     <= 2'd0;
         stopped_ff <= 1'b0;
      end else if (accept) begin
         s0_ff      <= s0_in;
         s1_ff      <= s1_in;
         s2_ff      <= s2_in;
         cnt_ff     <= cnt_in;
         stopped_ff <= stopped_in;
      end
   end

endmodule

// File: design/b64d_fifo.sv
// b64d_fifo: short queue of work items between the front and back ends.
// Depends on b64d_pkg for the work item type.
module b64d_fifo
   import b64d_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   input  logic    pop,
   output cmd_type head,
   output logic    empty,
   output logic    full
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   cmd_type        mem_ff [DEPTH];
   logic [AW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic           do_push, do_pop;

   assign empty   = (cnt_ff == CW'(0));
   assign full    = (cnt_ff == CW'(DEPTH));
   assign head    = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? AW'(0) : AW'(wr_ptr_ff + AW'(1));
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? AW'(0) : AW'(rd_ptr_ff + AW'(1));
      end
      if (do_push && !do_pop) begin
         cnt_in = CW'(cnt_ff + CW'(1));
      end else if (do_pop && !do_push) begin
         cnt_in = CW'(cnt_ff - CW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: design/b64d_back.sv
// b64d_back: drains work items into the result register, one result per cycle
// if rsp_ready allows; keeps the per-message byte count. Depends on b64d_pkg.
module b64d_back
   import b64d_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  cmd_type head,
   input  logic    head_valid,
   output logic    pop,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic [1:0]  idx_ff, idx_in;
   logic [31:0] count_ff, count_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;
   logic        load, issue, is_byte, last;
   logic [7:0]  sel_byte;

   assign load  = !rsp_valid_ff || rsp_ready;
   assign issue = load && head_valid;

   always_comb begin
      case (idx_ff)
         2'd0:    sel_byte = head.data0;
         2'd1:    sel_byte = head.data1;
         default: sel_byte = head.data2;
      endcase
      is_byte = (idx_ff < head.nbytes);
      last    = is_byte ? ((2'(idx_ff + 2'd1) == head.nbytes) && !head.done) : 1'b1;
   end

   always_comb begin
      idx_in       = idx_ff;
      count_in     = count_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = load ? head_valid : rsp_valid_ff;
      if (issue) begin
         idx_in = last ? 2'd0 : 2'(idx_ff + 2'd1);
         if (is_byte) begin
            rsp_data_in.out_byte     = sel_byte;
            rsp_data_in.byte_valid   = 1'b1;
            rsp_data_in.message_done = 1'b0;
            rsp_data_in.byte_count   = 32'd0;
            count_in = (count_ff == COUNT_MAX) ? count_ff : count_ff + 32'd1;
         end else begin
            rsp_data_in.out_byte     = 8'd0;
            rsp_data_in.byte_valid   = 1'b0;
            rsp_data_in.message_done = 1'b1;
            rsp_data_in.byte_count   = count_ff;
            count_in = 32'd0;
         end
      end
   end

   assign pop       = issue && last;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= 2'd0;
         count_ff     <= 32'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// File: design/base64_stream_decoder.sv
// base64_stream_decoder: top level of the streaming base64 decoder.
// Depends on b64d_pkg, b64d_front, b64d_fifo and b64d_back.
//
// Usage:
//  - req channel: one character per transaction (req_data.in_char) with an
//    end_of_message flag on the last character of a message.
//  - rsp channel: decoded bytes (byte_valid=1), and after the last character of
//    each message one closing result (message_done=1) carrying the byte count.
//  - Decoding stops at '=' or any non-alphabet char; a partial group of k
//    sextets then yields k-1 bytes and later chars are dropped until end of message.
//  - Path: a character's work item is written into the work queue, then loaded
//    from the queue head into the result register that drives rsp_data.
//  - Throughput: one character per cycle in while the work queue has room; the
//    back end emits one result per cycle unless rsp_ready holds it. A character
//    gives 1 to 4 results, and a character with no result never reaches the back
//    end. The QUEUE_DEPTH-entry work queue absorbs bursts.
//  - Stalls: with rsp_ready low the result register holds; the front keeps
//    taking characters until the work queue fills, then drops req_ready.
//  - Reset: synchronous, active high; empties the queue, the result register,
//    the sextet buffer and the byte count. No clearing pass is needed.
module base64_stream_decoder
   import b64d_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   cmd_type q_cmd, q_head;
   logic    q_push, q_pop, q_empty, q_full;

   // Front end: classify characters, build work items
   b64d_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_cmd     (q_cmd)
   );

   // Queue decouples character intake from result delivery
   b64d_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_cmd),
      .pop       (q_pop),
      .head      (q_head),
      .empty     (q_empty),
      .full      (q_full)
   );

   // Back end: serialize bytes and closing results
   b64d_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (q_head),
      .head_valid (!q_empty),
      .pop        (q_pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

   // Result register is empty right after reset
   a_reset_clears_rsp : assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid set after reset");

   // A result is either a byte or a closing transaction, never both
   a_rsp_kind : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.byte_valid != rsp_data.message_done))
      else $error("result kind flags inconsistent");

   // Byte results carry no count, closing results carry no byte
   a_rsp_zero_fields : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.byte_valid ? (rsp_data.byte_count == 32'd0)
                                         : (rsp_data.out_byte == 8'd0)))
      else $error("unused result field not zero");

   // Front never pushes into a full queue
   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("work queue overflow");

   // Back end only pops an entry that is present
   a_no_underflow : assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("work queue underflow");

endmodule

// File: verif/tb.sv
`timescale 1ns / 100ps
// tb: self-checking testbench for base64_stream_decoder, with a scoreboard class
// that predicts every decoded byte and closing count. Depends on b64d_pkg and the RTL.
module tb;
   import b64d_pkg::*;

   // Scoreboard: keeps its own copy of the decoder state, turns each accepted
   // character into the results it should cause, and checks results in order.
   class decode_scoreboard;
      rsp_type     expected_results[$];
      logic [5:0]  group_sextets[3];
      int unsigned held;
      bit          halted;
      logic [31:0] byte_total;
      int          failures;

      function new();
         failures = 0;
         clear_message();
      endfunction

      // sextet value of an ASCII code, -1 outside the alphabet
      static function int sextet_value(logic [7:0] c);
         if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) return int'(c - CHAR_UPPER_A);
         if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) return int'(c - CHAR_LOWER_A) + 26;
         if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) return int'(c - CHAR_DIGIT_0) + 52;
         if (c == CHAR_PLUS) return 62;
         if (c == CHAR_SLASH) return 63;
         return -1;
      endfunction

      function void clear_group();
         held = 0;
         foreach (group_sextets[i]) group_sextets[i] = 6'd0;
      endfunction

      function void clear_message();
         clear_group();
         halted     = 1'b0;
         byte_total = '0;
      endfunction

      function void push_byte(logic [7:0] b);
         rsp_type r;
         r            = '0;
         r.out_byte   = b;
         r.byte_valid = 1'b1;
         expected_results.push_back(r);
         if (byte_total != COUNT_MAX) byte_total++;
      endfunction

      // first nbytes bytes of the 24-bit group; unheld sextets are zero
      function void push_group(logic [5:0] last, int unsigned nbytes);
         logic [23:0] bits;
         bits = {group_sextets[0], group_sextets[1], group_sextets[2], last};
         if (nbytes > 0) push_byte(bits[23:16]);
         if (nbytes > 1) push_byte(bits[15:8]);
         if (nbytes > 2) push_byte(bits[7:0]);
      endfunction

      // partial group of k sextets gives k-1 bytes
      function void flush_group();
         if (held > 1) push_group(6'd0, held - 1);
         clear_group();
      endfunction

      function void note_char(req_type t);
         int      code;
         rsp_type r;
         if (!halted) begin
            code = sextet_value(t.in_char);
            if (code < 0) begin
               flush_group();
               halted = 1'b1;
            end else if (held == 3) begin
               push_group(code[5:0], 3);
               clear_group();
            end else begin
               group_sextets[held] = code[5:0];
               held++;
            end
         end
         if (t.end_of_message) begin
            if (!halted) flush_group();
            r              = '0;
            r.message_done = 1'b1;
            r.byte_count   = byte_total;
            expected_results.push_back(r);
            clear_message();
         end
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (expected_results.size() == 0) begin
            $error("unexpected result: out_byte %h byte_valid %b message_done %b byte_count %0d",
                   got.out_byte, got.byte_valid, got.message_done, got.byte_count);
            failures++;
            return;
         end
         want = expected_results.pop_front();
         if (got.out_byte !== want.out_byte) begin
            $error("out_byte: expected %h, actual %h", want.out_byte, got.out_byte);
            failures++;
         end
         if (got.byte_valid !== want.byte_valid) begin
            $error("byte_valid: expected %b, actual %b", want.byte_valid, got.byte_valid);
            failures++;
         end
         if (got.message_done !== want.message_done) begin
            $error("message_done: expected %b, actual %b", want.message_done, got.message_done);
            failures++;
         end
         if (got.byte_count !== want.byte_count) begin
            $error("byte_count: expected %0d, actual %0d", want.byte_count, got.byte_count);
            failures++;
         end
      endfunction
   endclass

   localparam int ITEM_TARGET  = 380;  // characters sent at least, directed part included
   localparam int QUIET_LIMIT  = 400;  // cycles with no transaction before giving up
   localparam int DRAIN_CYCLES = 20;   // settle time once nothing is outstanding

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   decode_scoreboard board = new();

   // calm flags switch off idling for stretches, so back-to-back traffic is covered
   bit req_calm = 1'b0;
   bit rsp_calm = 1'b0;
   int sent_items = 0;

   base64_stream_decoder u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Monitor: sample both channels at the edge. The input is noted before the
   // result is checked; a result never belongs to a char taken at the same edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) board.note_char(req_data);
         if (rsp_valid && rsp_ready) board.check_result(rsp_data);
      end
   end

   // Watchdog: ends the run after too long without any transaction.
   initial begin
      int quiet;
      quiet = 0;
      while (reset) @(posedge clock);
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
         else quiet++;
      end
      $display("end of test: mismatches");
      $finish;
   end

   // Result side: random stall before each result, with calm stretches.
   initial begin
      int unsigned stall;
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(0, 19) == 0) rsp_calm = !rsp_calm;
         stall = rsp_calm ? 0 : $urandom_range(0, 14);
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   function automatic logic [7:0] char_of_sextet(int v);
      if (v < 26) return CHAR_UPPER_A + 8'(v);
      if (v < 52) return CHAR_LOWER_A + 8'(v - 26);
      if (v < 62) return CHAR_DIGIT_0 + 8'(v - 52);
      if (v == 62) return CHAR_PLUS;
      return CHAR_SLASH;
   endfunction

   function automatic logic [7:0] random_alpha();
      return char_of_sextet($urandom_range(0, 63));
   endfunction

   // any non-alphabet code; pad is favored since it is the usual stop
   function automatic logic [7:0] random_stop();
      logic [7:0] c;
      if ($urandom_range(0, 1) == 0) return CHAR_PAD;
      do c = 8'($urandom_range(0, 255)); while (decode_scoreboard::sextet_value(c) >= 0);
      return c;
   endfunction

   // One transaction. Valid stays high across back-to-back chars; it is only
   // lowered when a gap is drawn, so it gets one assignment per time step.
   task automatic send_char(logic [7:0] c, logic eom);
      int unsigned gap;
      req_type     t;
      sent_items++;
      gap              = req_calm ? 0 : $urandom_range(0, 14);
      t.in_char        = c;
      t.end_of_message = eom;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= t;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
   endtask

   // Mostly well-formed messages (full groups plus a tail, often padded),
   // otherwise broken ones with a stray stop char, or raw noise.
   task automatic send_random_message();
      logic [7:0] msg[$];
      int         kind;
      int         n;
      kind = $urandom_range(0, 9);
      if (kind <= 6) begin
         n = 4 * $urandom_range(0, 3) + $urandom_range(0, 3);
         for (int i = 0; i < n; i++) msg.push_back(random_alpha());
         if (kind <= 3 && n % 4 != 0)
            for (int i = n % 4; i < 4; i++) msg.push_back(CHAR_PAD);
      end else if (kind <= 8) begin
         n = $urandom_range(0, 6);
         for (int i = 0; i < n; i++) msg.push_back(random_alpha());
         msg.push_back(random_stop());
         n = $urandom_range(0, 3);
         for (int i = 0; i < n; i++) msg.push_back(8'($urandom_range(0, 255)));
      end else begin
         n = $urandom_range(1, 6);
         for (int i = 0; i < n; i++) msg.push_back(8'($urandom_range(0, 255)));
      end
      if (msg.size() == 0) msg.push_back(random_alpha());
      if ($urandom_range(0, 5) == 0) req_calm = !req_calm;
      foreach (msg[i]) send_char(msg[i], i == msg.size() - 1);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed part
      send_text("TWFu");      // end of message on the fourth sextet: 3 bytes + close
      send_text("AZaz09+/");  // alphabet edges, two full groups
      send_text("QQ==");      // 2 sextets then pad; second pad ignored, eom still honored
      send_text("QUI=");      // 3 sextets then pad
      send_text("Q");         // lone sextet at end of message yields no byte
      send_char(8'hff, 1'b1); // high code stops at once: empty message, count zero
      send_text("QUJ");       // partial group flushed by end of message

      while (sent_items < ITEM_TARGET) send_random_message();
      req_valid <= 1'b0;

      // wait for every expected result, then give stray results time to show
      do @(posedge clock); while (board.expected_results.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (board.failures == 0 && board.expected_results.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

// File: filelist.f
design/b64d_pkg.sv
design/b64d_front.sv
design/b64d_fifo.sv
design/b64d_back.sv
design/base64_stream_decoder.sv
verif/tb.sv
